// ===== hdl/sld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sld_pkg;

    localparam logic [7:0] BYTE_START   = 8'h7F;
    localparam logic [7:0] BYTE_END     = 8'h70;
    localparam logic [7:0] BYTE_ESC     = 8'h7C;
    localparam logic [7:0] ESC_MASK     = 8'h20;
    localparam logic [7:0] CMD_CONNREQ  = 8'h7E;
    localparam logic [7:0] CMD_CONNACK  = 8'h7D;
    localparam logic [7:0] CMD_SUSPEND  = 8'h7B;
    localparam logic [7:0] CMD_RESUME   = 8'h7A;
    localparam logic [7:0] CMD_STAY1    = 8'h79;
    localparam logic [7:0] CMD_ACK1     = 8'h78;
    localparam logic [7:0] CMD_RELAX    = 8'h77;
    localparam logic [7:0] CMD_POWEROFF = 8'h76;
    localparam logic [7:0] CMD_STAY2    = 8'h75;
    localparam logic [7:0] CMD_ACK2     = 8'h74;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        EV_IGNORED   = 4'd0,
        EV_DATA      = 4'd1,
        EV_OPEN      = 4'd2,
        EV_END       = 4'd3,
        EV_COMMAND   = 4'd4,
        EV_UNKNOWN   = 4'd5,
        EV_OVERFLOW  = 4'd6,
        EV_STRAY     = 4'd7,
        EV_DUP_START = 4'd8,
        EV_DUP_END   = 4'd9,
        EV_ESCAPE    = 4'd10
    } t_event;

    typedef enum logic [3:0] {
        C_NONE     = 4'd0,
        C_CONNREQ  = 4'd1,
        C_CONNACK  = 4'd2,
        C_SUSPEND  = 4'd3,
        C_RESUME   = 4'd4,
        C_POWEROFF = 4'd5,
        C_STAY1    = 4'd6,
        C_STAY2    = 4'd7,
        C_RELAX    = 4'd8,
        C_ACK1     = 4'd9,
        C_ACK2     = 4'd10
    } t_cmd;

    typedef enum logic [2:0] {
        CLS_CMD     = 3'd0,
        CLS_UNKNOWN = 3'd1,
        CLS_START   = 3'd2,
        CLS_END     = 3'd3,
        CLS_ESC     = 3'd4,
        CLS_DATA    = 3'd5
    } t_cls;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2
    } t_phase;

    typedef struct packed {
        t_cls       cls;
        t_cmd       cmd;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        t_event      event_kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_len;
        t_cmd        command;
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        link_connected;
        logic        awake_hold;
    } t_result;

    function automatic t_item classify(input logic [7:0] b);
        t_item it;
        it.cls  = CLS_DATA;
        it.cmd  = C_NONE;
        it.data = b;
        if (b > BYTE_END && b < BYTE_START && b != BYTE_ESC) begin
            it.cls = CLS_CMD;
            unique case (b)
                CMD_CONNREQ:  it.cmd = C_CONNREQ;
                CMD_CONNACK:  it.cmd = C_CONNACK;
                CMD_SUSPEND:  it.cmd = C_SUSPEND;
                CMD_RESUME:   it.cmd = C_RESUME;
                CMD_POWEROFF: it.cmd = C_POWEROFF;
                CMD_STAY1:    it.cmd = C_STAY1;
                CMD_STAY2:    it.cmd = C_STAY2;
                CMD_RELAX:    it.cmd = C_RELAX;
                CMD_ACK1:     it.cmd = C_ACK1;
                CMD_ACK2:     it.cmd = C_ACK2;
                default:      it.cls = CLS_UNKNOWN;
            endcase
        end else if (b == BYTE_START) begin
            it.cls = CLS_START;
        end else if (b == BYTE_END) begin
            it.cls = CLS_END;
        end else if (b == BYTE_ESC) begin
            it.cls = CLS_ESC;
        end
        return it;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sld_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/sld_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sld_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_len;
    logic [3:0]  command;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        link_connected;
    logic        awake_hold;

    modport source (
        output valid, input ready,
        output event_kind, output data_byte, output byte_index, output frame_len,
        output command, output reply_valid, output reply_byte,
        output link_connected, output awake_hold
    );
    modport sink (
        input valid, output ready,
        input event_kind, input data_byte, input byte_index, input frame_len,
        input command, input reply_valid, input reply_byte,
        input link_connected, input awake_hold
    );
endinterface
`default_nettype wire

// ===== hdl/sld_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sld_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [7:0]       i_rx_byte,
    output logic             o_valid,
    input  wire              i_ready,
    output sld_pkg::t_item   o_item
);
    logic           r_vld;
    sld_pkg::t_item r_item;
    logic           n_vld;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        n_vld = r_vld;
        if (i_valid && o_ready) begin
            n_vld = 1'b1;
        end else if (r_vld && i_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // classify on the way in; the payload register needs no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= sld_pkg::classify(i_rx_byte);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/sld_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sld_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  sld_pkg::t_item   i_item,
    output logic             o_valid,
    input  wire              i_ready,
    output sld_pkg::t_item   o_item
);
    sld_pkg::t_item                  r_mem [sld_pkg::QDEPTH];
    logic [sld_pkg::QPTR_W-1:0]      r_wptr;
    logic [sld_pkg::QPTR_W-1:0]      r_rptr;
    logic [sld_pkg::QCNT_W-1:0]      r_cnt;
    logic                            push;
    logic                            pop;

    assign o_ready = r_cnt != sld_pkg::QCNT_W'(sld_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == sld_pkg::QPTR_W'(sld_pkg::QDEPTH - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == sld_pkg::QPTR_W'(sld_pkg::QDEPTH - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/sld_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sld_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [15:0]        i_max_frame_len,
    input  wire                i_valid,
    output logic               o_ready,
    input  sld_pkg::t_item     i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output sld_pkg::t_result   o_res
);
    sld_pkg::t_phase  r_phase;
    logic             r_conn;
    logic [15:0]      r_count;
    logic             r_hold;
    logic             r_out_vld;
    sld_pkg::t_result r_res;

    sld_pkg::t_phase  n_phase;
    logic             n_conn;
    logic [15:0]      n_count;
    logic             n_hold;
    sld_pkg::t_result n_res;
    logic [7:0]       store_val;
    logic             take;

    assign o_ready = !r_out_vld || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_out_vld;
    assign o_res   = r_res;

    assign store_val = (r_phase == sld_pkg::PH_ESC) ? (i_item.data ^ sld_pkg::ESC_MASK)
                                                    : i_item.data;

    always_comb begin
        n_phase = r_phase;
        n_conn  = r_conn;
        n_count = r_count;
        n_hold  = r_hold;
        n_res   = '0;
        n_res.event_kind = sld_pkg::EV_IGNORED;
        n_res.command    = sld_pkg::C_NONE;
        if (i_item.cls == sld_pkg::CLS_CMD) begin
            n_res.event_kind = sld_pkg::EV_COMMAND;
            n_res.command    = i_item.cmd;
            unique case (i_item.cmd)
                sld_pkg::C_CONNREQ: begin
                    n_conn = 1'b1;
                    n_phase = sld_pkg::PH_WAIT;
                    n_count = '0;
                    n_res.reply_valid = 1'b1;
                    n_res.reply_byte  = sld_pkg::CMD_CONNACK;
                end
                sld_pkg::C_CONNACK: begin
                    n_conn = 1'b1;
                    n_phase = sld_pkg::PH_WAIT;
                    n_count = '0;
                end
                sld_pkg::C_POWEROFF: begin
                    n_conn = 1'b0;
                    n_hold = 1'b0;
                end
                sld_pkg::C_STAY1: begin
                    n_hold = 1'b1;
                    n_res.reply_valid = 1'b1;
                    n_res.reply_byte  = sld_pkg::CMD_ACK1;
                end
                sld_pkg::C_STAY2: begin
                    n_hold = 1'b1;
                    n_res.reply_valid = 1'b1;
                    n_res.reply_byte  = sld_pkg::CMD_ACK2;
                end
                sld_pkg::C_RELAX: begin
                    n_hold = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_item.cls == sld_pkg::CLS_UNKNOWN) begin
            n_res.event_kind = sld_pkg::EV_UNKNOWN;
        end else if (r_conn) begin
            priority if (r_phase == sld_pkg::PH_ESC
                         || (r_phase == sld_pkg::PH_FRAME
                             && i_item.cls == sld_pkg::CLS_DATA)) begin
                // store the byte or drop it past the limit
                if (r_count < i_max_frame_len) begin
                    n_res.event_kind = sld_pkg::EV_DATA;
                    n_res.data_byte  = store_val;
                    n_res.byte_index = r_count;
                    n_count = r_count + 16'd1;
                end else begin
                    n_res.event_kind = sld_pkg::EV_OVERFLOW;
                end
                n_phase = sld_pkg::PH_FRAME;
            end else if (r_phase == sld_pkg::PH_FRAME) begin
                unique case (i_item.cls)
                    sld_pkg::CLS_START: begin
                        n_res.event_kind = sld_pkg::EV_DUP_START;
                        n_phase = sld_pkg::PH_WAIT;
                        n_count = '0;
                    end
                    sld_pkg::CLS_END: begin
                        n_res.event_kind = sld_pkg::EV_END;
                        n_res.frame_len  = r_count;
                        n_phase = sld_pkg::PH_WAIT;
                        n_count = '0;
                    end
                    default: begin
                        n_res.event_kind = sld_pkg::EV_ESCAPE;
                        n_phase = sld_pkg::PH_ESC;
                    end
                endcase
            end else begin
                unique case (i_item.cls)
                    sld_pkg::CLS_START: begin
                        n_res.event_kind = sld_pkg::EV_OPEN;
                        n_phase = sld_pkg::PH_FRAME;
                        n_count = '0;
                    end
                    sld_pkg::CLS_END: n_res.event_kind = sld_pkg::EV_DUP_END;
                    default:          n_res.event_kind = sld_pkg::EV_STRAY;
                endcase
            end
        end
        n_res.link_connected = n_conn;
        n_res.awake_hold     = n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sld_pkg::PH_WAIT;
            r_conn    <= 1'b0;
            r_count   <= '0;
            r_hold    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_conn  <= n_conn;
                r_count <= n_count;
                r_hold  <= n_hold;
            end
            if (take) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/stuffed_link_rx_deframer.sv =====
// Path: an accepted byte passes the classify register, the two-entry queue and the result
//   register in that order; an output stall holds bytes back along this path.
// Throughput: one byte per cycle while o_ev.ready stays high; the back-end state update sets it.
// Reset: i_rst_n is synchronous, active low; it empties the pipeline, clears the link
//   state and loads max_frame_len with 1024.
`timescale 1ns / 1ps
`default_nettype none
module stuffed_link_rx_deframer (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sld_in_if.sink       i_rx,
    sld_out_if.source    o_ev,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [1:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [15:0]      r_max_len;
    logic             f_valid;
    logic             f_ready;
    sld_pkg::t_item   f_item;
    logic             q_valid;
    logic             q_ready;
    sld_pkg::t_item   q_item;
    sld_pkg::t_result res;
    logic             addr_hit;

    // single register: decode ignores the byte offset
    assign addr_hit = paddr[1:0] == paddr[1:0];
    assign pready   = 1'b1;
    assign prdata   = {16'd0, r_max_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= sld_pkg::MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && addr_hit) begin
            r_max_len <= pwdata[15:0];
        end
    end

    sld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .o_ready   (i_rx.ready),
        .i_rx_byte (i_rx.rx_byte),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_item    (f_item)
    );

    sld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    sld_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_frame_len (r_max_len),
        .i_valid         (q_valid),
        .o_ready         (q_ready),
        .i_item          (q_item),
        .o_valid         (o_ev.valid),
        .i_ready         (o_ev.ready),
        .o_res           (res)
    );

    assign o_ev.event_kind     = res.event_kind;
    assign o_ev.data_byte      = res.data_byte;
    assign o_ev.byte_index     = res.byte_index;
    assign o_ev.frame_len      = res.frame_len;
    assign o_ev.command        = res.command;
    assign o_ev.reply_valid    = res.reply_valid;
    assign o_ev.reply_byte     = res.reply_byte;
    assign o_ev.link_connected = res.link_connected;
    assign o_ev.awake_hold     = res.awake_hold;
endmodule
`default_nettype wire

// ===== tb/sv/sld_deframe_checker.sv =====
`timescale 1ns / 1ps
module sld_deframe_checker #(
    parameter logic [1:0] MAX_LEN_ADDR = 2'd0
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sld_in_if           i_rx,
    sld_out_if          i_ev,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [1:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    input  wire         i_pready,
    output int          o_fail_count,
    output int          o_outstanding
);
    sld_pkg::t_phase  frame_phase;
    logic             link_up;
    logic             hold_req;
    logic [15:0]      stored_count;
    logic [15:0]      len_limit;
    sld_pkg::t_result expected_events[$];
    int               fail_total;

    initial begin
        fail_total = 0;
    end

    function automatic void store_payload(input logic [7:0] d, inout sld_pkg::t_result r);
        if (stored_count < len_limit) begin
            r.event_kind = sld_pkg::EV_DATA;
            r.data_byte  = d;
            r.byte_index = stored_count;
            stored_count = stored_count + 16'd1;
        end else begin
            r.event_kind = sld_pkg::EV_OVERFLOW;
        end
    endfunction

    // Advance the link state by one received byte and return what it should report.
    function automatic sld_pkg::t_result deframe_byte(input logic [7:0] b);
        sld_pkg::t_result r;
        r = '0;
        if (b > sld_pkg::BYTE_END && b < sld_pkg::BYTE_START && b != sld_pkg::BYTE_ESC) begin
            // commands act in any phase; a pending escape survives all but CONNREQ and CONNACK
            r.event_kind = sld_pkg::EV_COMMAND;
            case (b)
                sld_pkg::CMD_CONNREQ, sld_pkg::CMD_CONNACK: begin
                    r.command    = (b == sld_pkg::CMD_CONNREQ) ? sld_pkg::C_CONNREQ
                                                               : sld_pkg::C_CONNACK;
                    link_up      = 1'b1;
                    frame_phase  = sld_pkg::PH_WAIT;
                    stored_count = 16'd0;
                    if (b == sld_pkg::CMD_CONNREQ) begin
                        r.reply_valid = 1'b1;
                        r.reply_byte  = sld_pkg::CMD_CONNACK;
                    end
                end
                sld_pkg::CMD_SUSPEND: r.command = sld_pkg::C_SUSPEND;
                sld_pkg::CMD_RESUME:  r.command = sld_pkg::C_RESUME;
                sld_pkg::CMD_POWEROFF: begin
                    r.command = sld_pkg::C_POWEROFF;
                    link_up   = 1'b0;
                    hold_req  = 1'b0;
                end
                sld_pkg::CMD_STAY1: begin
                    r.command     = sld_pkg::C_STAY1;
                    hold_req      = 1'b1;
                    r.reply_valid = 1'b1;
                    r.reply_byte  = sld_pkg::CMD_ACK1;
                end
                sld_pkg::CMD_STAY2: begin
                    r.command     = sld_pkg::C_STAY2;
                    hold_req      = 1'b1;
                    r.reply_valid = 1'b1;
                    r.reply_byte  = sld_pkg::CMD_ACK2;
                end
                sld_pkg::CMD_RELAX: begin
                    r.command = sld_pkg::C_RELAX;
                    hold_req  = 1'b0;
                end
                sld_pkg::CMD_ACK1: r.command = sld_pkg::C_ACK1;
                sld_pkg::CMD_ACK2: r.command = sld_pkg::C_ACK2;
                default:           r.event_kind = sld_pkg::EV_UNKNOWN;
            endcase
        end else if (link_up) begin
            case (frame_phase)
                sld_pkg::PH_FRAME: begin
                    if (b == sld_pkg::BYTE_START) begin
                        r.event_kind = sld_pkg::EV_DUP_START;
                        frame_phase  = sld_pkg::PH_WAIT;
                        stored_count = 16'd0;
                    end else if (b == sld_pkg::BYTE_END) begin
                        r.event_kind = sld_pkg::EV_END;
                        r.frame_len  = stored_count;
                        stored_count = 16'd0;
                        frame_phase  = sld_pkg::PH_WAIT;
                    end else if (b == sld_pkg::BYTE_ESC) begin
                        r.event_kind = sld_pkg::EV_ESCAPE;
                        frame_phase  = sld_pkg::PH_ESC;
                    end else begin
                        store_payload(b, r);
                    end
                end
                sld_pkg::PH_ESC: begin
                    store_payload(b ^ sld_pkg::ESC_MASK, r);
                    frame_phase = sld_pkg::PH_FRAME;
                end
                default: begin
                    if (b == sld_pkg::BYTE_START) begin
                        r.event_kind = sld_pkg::EV_OPEN;
                        frame_phase  = sld_pkg::PH_FRAME;
                        stored_count = 16'd0;
                    end else if (b == sld_pkg::BYTE_END) begin
                        r.event_kind = sld_pkg::EV_DUP_END;
                    end else begin
                        r.event_kind = sld_pkg::EV_STRAY;
                    end
                end
            endcase
        end
        r.link_connected = link_up;
        r.awake_hold     = hold_req;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        sld_pkg::t_result want;
        if (!i_rst_n) begin
            frame_phase  = sld_pkg::PH_WAIT;
            link_up      = 1'b0;
            hold_req     = 1'b0;
            stored_count = 16'd0;
            len_limit    = sld_pkg::MAX_LEN_RESET;
            expected_events.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MAX_LEN_ADDR) begin
                len_limit = i_pwdata[15:0];
            end
            if (i_ev.valid && i_ev.ready) begin
                if (expected_events.size() == 0) begin
                    $error("result with nothing expected: event_kind %0d", i_ev.event_kind);
                    fail_total++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.event_kind, i_ev.event_kind);
                    check_field("data_byte", want.data_byte, i_ev.data_byte);
                    check_field("byte_index", want.byte_index, i_ev.byte_index);
                    check_field("frame_len", want.frame_len, i_ev.frame_len);
                    check_field("command", want.command, i_ev.command);
                    check_field("reply_valid", want.reply_valid, i_ev.reply_valid);
                    check_field("reply_byte", want.reply_byte, i_ev.reply_byte);
                    check_field("link_connected", want.link_connected, i_ev.link_connected);
                    check_field("awake_hold", want.awake_hold, i_ev.awake_hold);
                end
            end
            if (i_rx.valid && i_rx.ready) begin
                expected_events.push_back(deframe_byte(i_rx.rx_byte));
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= expected_events.size();
    end

endmodule

// ===== tb/sv/tb_stuffed_link_rx_deframer.sv =====
`timescale 1ns / 1ps
module tb_stuffed_link_rx_deframer;

    localparam logic [1:0] ADDR_MAX_FRAME_LEN = 2'd0;
    // command-range bytes that name no command
    localparam logic [7:0] CMD_UNDEF_LO  = 8'h71;
    localparam logic [7:0] CMD_UNDEF_MID = 8'h72;
    localparam logic [7:0] CMD_UNDEF_HI  = 8'h73;
    localparam int PHASE_ITEMS     = 300;
    localparam int PIPE_LATENCY    = 4;
    localparam int HOLD_OFF_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;
    int          sent_count = 0;

    sld_in_if  rx_ch ();
    sld_out_if ev_ch ();

    stuffed_link_rx_deframer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .o_ev    (ev_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sld_deframe_checker #(
        .MAX_LEN_ADDR (ADDR_MAX_FRAME_LEN)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_rx          (rx_ch),
        .i_ev          (ev_ch),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #1 clk = ~clk;

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (((sent_count / 70) % 3) == 1) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        sent_count++;
    endtask

    task automatic drain_block();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_FRAME_LEN;
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly well-formed frames with random payload; a few break the framing.
    task automatic send_random_frame(input logic [15:0] limit);
        int n;
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            send_byte($urandom_range(0, 1) ? sld_pkg::CMD_CONNREQ : sld_pkg::CMD_CONNACK);
        end
        if ($urandom_range(0, 7) == 0) begin
            send_byte(8'($urandom()));
        end
        if (limit <= 16'd16 && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(0, limit + 2);
        end else if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(11, 60);
        end else begin
            n = $urandom_range(0, 10);
        end
        send_byte(sld_pkg::BYTE_START);
        repeat (n) begin
            b = 8'($urandom());
            if ($urandom_range(0, 24) == 0) begin
                b = 8'($urandom_range(CMD_UNDEF_LO, sld_pkg::CMD_CONNREQ));
                if (b == sld_pkg::BYTE_ESC) begin
                    b = sld_pkg::CMD_RELAX;
                end
                send_byte(b);
            end else if (b >= sld_pkg::BYTE_END && b <= sld_pkg::BYTE_START
                         && $urandom_range(0, 11) != 0) begin
                send_byte(sld_pkg::BYTE_ESC);
                send_byte(b ^ sld_pkg::ESC_MASK);
            end else begin
                send_byte(b);
            end
        end
        if ($urandom_range(0, 11) != 0) begin
            send_byte(sld_pkg::BYTE_END);
        end
        if ($urandom_range(0, 14) == 0) begin
            send_byte(sld_pkg::BYTE_END);
        end
    endtask

    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        ev_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = (((taken / 80) % 3) == 2) ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                ev_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            ev_ch.ready <= 1'b1;
            do @(posedge clk); while (!ev_ch.valid);
            taken++;
            // hold off long enough for the input side to back up
            if (taken % 700 == 250) begin
                ev_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [7:0]  seq[$];
        logic [15:0] limits[$];
        int          base;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 2'd0;
        pwdata        = 32'd0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unconnected link, unknown commands, framing, escapes and commands at reset limit
        seq = '{8'h00, sld_pkg::BYTE_START, CMD_UNDEF_LO, CMD_UNDEF_MID, CMD_UNDEF_HI,
                sld_pkg::CMD_CONNREQ, sld_pkg::BYTE_END, 8'h41, sld_pkg::BYTE_START,
                8'h00, 8'hFF, sld_pkg::BYTE_ESC, sld_pkg::CMD_STAY1, 8'h5D,
                sld_pkg::BYTE_ESC, sld_pkg::BYTE_ESC, sld_pkg::BYTE_ESC,
                sld_pkg::BYTE_START, sld_pkg::BYTE_START, sld_pkg::BYTE_START,
                sld_pkg::BYTE_END, sld_pkg::CMD_SUSPEND, sld_pkg::CMD_RESUME,
                sld_pkg::CMD_ACK1, sld_pkg::CMD_ACK2};
        foreach (seq[i]) send_byte(seq[i]);

        // overflow, escaped overflow and power-off with a one-byte limit
        drain_block();
        write_max_len(16'd1);
        seq = '{sld_pkg::CMD_CONNACK, sld_pkg::CMD_STAY2, sld_pkg::CMD_RELAX,
                sld_pkg::BYTE_START, 8'h01, 8'h02, sld_pkg::BYTE_ESC, 8'h50,
                sld_pkg::BYTE_END, sld_pkg::CMD_POWEROFF, 8'h41, sld_pkg::CMD_CONNACK};
        foreach (seq[i]) send_byte(seq[i]);

        limits = '{16'd3, 16'hFFFF, 16'd0, 16'd8, 16'd1, 16'($urandom_range(2, 40))};
        foreach (limits[p]) begin
            drain_block();
            write_max_len(limits[p]);
            base = sent_count;
            send_byte(sld_pkg::CMD_CONNACK);
            while (sent_count < base + PHASE_ITEMS) send_random_frame(limits[p]);
        end

        drain_block();
        repeat (PIPE_LATENCY) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== stuffed_link_rx_deframer.f =====
hdl/sld_pkg.sv
hdl/sld_in_if.sv
hdl/sld_out_if.sv
hdl/sld_front.sv
hdl/sld_queue.sv
hdl/sld_back.sv
hdl/stuffed_link_rx_deframer.sv
tb/sv/sld_deframe_checker.sv
tb/sv/tb_stuffed_link_rx_deframer.sv
